@@ rtl/bba_pkg.sv @@
// shared types and constants for the bitmap block allocator
// no dependencies; imported by every rtl module of the block
package bba_pkg;

    localparam int DEFAULT_BLOCKS    = 1024;
    localparam int DEFAULT_WORD_BITS = 32;

    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int BLOCK_SPAN  = 1024;
    localparam int RECIP_SHIFT = 20;

    localparam logic [COUNT_W-1:0] CFG_RESET_COUNT = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_en_t;

endpackage

@@ rtl/bba_bitmap_mem.sv @@
// bitmap store: one write port, one read port with registered read data
// depends on bba_pkg for the port enable struct
module bba_bitmap_mem import bba_pkg::*; #(
    parameter int WORDS     = DEFAULT_BLOCKS / DEFAULT_WORD_BITS,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  logic                         aclk,
    input  mem_en_t                      mem_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]         rd_data,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]         wr_data
);

    logic [WORD_BITS-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (mem_en.wr) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_en.rd) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bba_engine.sv @@
// request sequencer: clear pass, first-fit word scan, free read-modify-write,
// result register; depends on bba_pkg and drives bba_bitmap_mem
module bba_engine import bba_pkg::*; #(
    parameter int BLOCKS    = DEFAULT_BLOCKS,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [COUNT_W-1:0]   limit,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [INDEX_W-1:0]   s_block_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [INDEX_W-1:0]   m_block_number,
    output logic [STATUS_W-1:0]  m_status,
    output mem_en_t              mem_en,
    output logic [((((BLOCKS + WORD_BITS - 1) / WORD_BITS) > 1) ?
                   $clog2((BLOCKS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] rd_addr,
    input  logic [WORD_BITS-1:0] rd_data,
    output logic [((((BLOCKS + WORD_BITS - 1) / WORD_BITS) > 1) ?
                   $clog2((BLOCKS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] wr_addr,
    output logic [WORD_BITS-1:0] wr_data
);

    localparam int WORDS    = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int BASE_W   = COUNT_W + 1;
    localparam int RECIP    = (1 << RECIP_SHIFT) / WORD_BITS;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = INDEX_W + RECIP_W;
    localparam int QW_W     = INDEX_W + BIT_W + 1;

    typedef enum logic [6:0] {
        S_CLR    = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_FDIV   = 7'b0001000,
        S_FRD    = 7'b0010000,
        S_FWR    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]    chk_addr_reg, chk_addr_next;
    logic [BASE_W-1:0]    chk_base_reg, chk_base_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [INDEX_W-1:0]   q0_reg, q0_next;
    logic [ADDR_W-1:0]    wa_reg, wa_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [INDEX_W-1:0]   res_num_reg, res_num_next;
    status_t              res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]   m_num_reg, m_num_next;
    status_t              m_status_reg, m_status_next;

    logic [WORD_BITS-1:0] avail;
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic                 scan_last;
    logic [PROD_W-1:0]    prod;
    logic [INDEX_W-1:0]   qw;
    logic [INDEX_W-1:0]   rem;
    logic [INDEX_W-1:0]   q_corr;
    logic [BIT_W-1:0]     bit_corr;

    // free bits of the word under test that lie below the active count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = !rd_data[b] && ((chk_base_reg + BASE_W'(b)) < BASE_W'(limit));
        end
    end

    // lowest available bit
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                found = 1'b1;
                pos   = BIT_W'(b);
            end
        end
    end

    assign scan_last = (chk_base_reg + BASE_W'(WORD_BITS)) >= BASE_W'(limit);

    // word index of a freed block by reciprocal multiply, then one correction
    assign prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign qw   = INDEX_W'(QW_W'(q0_reg) * QW_W'(WORD_BITS));
    assign rem  = idx_reg - qw;

    always_comb begin
        if (rem >= INDEX_W'(WORD_BITS)) begin
            q_corr   = q0_reg + INDEX_W'(1);
            bit_corr = BIT_W'(rem - INDEX_W'(WORD_BITS));
        end else begin
            q_corr   = q0_reg;
            bit_corr = BIT_W'(rem);
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        chk_addr_next   = chk_addr_reg;
        chk_base_next   = chk_base_reg;
        idx_next        = idx_reg;
        q0_next         = q0_reg;
        wa_next         = wa_reg;
        bit_next        = bit_reg;
        res_num_next    = res_num_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_num_next      = m_num_reg;
        m_status_next   = m_status_reg;
        mem_en          = '0;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_data         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                mem_en.wr = 1'b1;
                wr_addr   = clr_addr_reg;
                wr_data   = '0;
                if (clr_addr_reg == ADDR_W'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == OP_ALLOC) begin
                        if (limit == '0) begin
                            res_num_next    = '0;
                            res_status_next = STATUS_FULL;
                            state_next      = S_RESULT;
                        end else begin
                            mem_en.rd     = 1'b1;
                            rd_addr       = '0;
                            chk_addr_next = '0;
                            chk_base_next = '0;
                            state_next    = S_SCAN;
                        end
                    end else begin
                        if (COUNT_W'(s_block_index) < limit) begin
                            idx_next   = s_block_index;
                            state_next = S_FDIV;
                        end else begin
                            res_num_next    = '0;
                            res_status_next = STATUS_RANGE;
                            state_next      = S_RESULT;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    mem_en.wr       = 1'b1;
                    wr_addr         = chk_addr_reg;
                    wr_data         = rd_data | (WORD_BITS'(1) << pos);
                    res_num_next    = INDEX_W'(chk_base_reg + BASE_W'(pos));
                    res_status_next = STATUS_DONE;
                    state_next      = S_RESULT;
                end else if (scan_last) begin
                    res_num_next    = '0;
                    res_status_next = STATUS_FULL;
                    state_next      = S_RESULT;
                end else begin
                    mem_en.rd     = 1'b1;
                    rd_addr       = chk_addr_reg + ADDR_W'(1);
                    chk_addr_next = chk_addr_reg + ADDR_W'(1);
                    chk_base_next = chk_base_reg + BASE_W'(WORD_BITS);
                end
            end
            S_FDIV: begin
                q0_next    = INDEX_W'(prod >> RECIP_SHIFT);
                state_next = S_FRD;
            end
            S_FRD: begin
                mem_en.rd  = 1'b1;
                rd_addr    = ADDR_W'(q_corr);
                wa_next    = ADDR_W'(q_corr);
                bit_next   = bit_corr;
                state_next = S_FWR;
            end
            S_FWR: begin
                mem_en.wr       = 1'b1;
                wr_addr         = wa_reg;
                wr_data         = rd_data & ~(WORD_BITS'(1) << bit_reg);
                res_num_next    = idx_reg;
                res_status_next = STATUS_DONE;
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_num_next    = res_num_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_addr_reg   <= chk_addr_next;
        chk_base_reg   <= chk_base_next;
        idx_reg        <= idx_next;
        q0_reg         <= q0_next;
        wa_reg         <= wa_next;
        bit_reg        <= bit_next;
        res_num_reg    <= res_num_next;
        res_status_reg <= res_status_next;
        m_num_reg      <= m_num_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_block_number = m_num_reg;
    assign m_status       = m_status_reg;

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// Bitmap first-fit block allocator. One used/free bit per block, held in a
// single-port-read memory of WORD_BITS-bit words. After reset the block runs
// a clearing pass over every bitmap word with s_ready low. An allocate
// transfer scans the bitmap one memory word per cycle, reading the words up
// to the first free block (at most ceil(count/WORD_BITS)); a free finds the
// word by reciprocal multiply, then reads and rewrites it; an out of range
// free or a zero-count allocate goes straight to the result. The scan loop
// through the memory read port sets the allocate time. A result waits in an
// output register, so the next request is taken while it is pending.
// depends on bba_pkg, bba_bitmap_mem and bba_engine
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int BLOCKS    = DEFAULT_BLOCKS,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [INDEX_W-1:0]  s_block_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [INDEX_W-1:0]  m_block_number,
    output logic [STATUS_W-1:0] m_status
);

    localparam int WORDS     = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIMIT_CAP = (BLOCKS < BLOCK_SPAN) ? BLOCKS : BLOCK_SPAN;

    logic [COUNT_W-1:0]   blocks_in_use_reg, blocks_in_use_next;
    logic [COUNT_W-1:0]   limit;
    mem_en_t              mem_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;

    assign blocks_in_use_next = cfg_wr_en ? cfg_wr_data : blocks_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= CFG_RESET_COUNT;
        end else begin
            blocks_in_use_reg <= blocks_in_use_next;
        end
    end

    // active count, capped by storage size and block number span
    assign limit = (blocks_in_use_reg > COUNT_W'(LIMIT_CAP)) ?
                   COUNT_W'(LIMIT_CAP) : blocks_in_use_reg;

    bba_bitmap_mem #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .aclk    (aclk),
        .mem_en  (mem_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bba_engine #(
        .BLOCKS    (BLOCKS),
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .limit          (limit),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_block_index  (s_block_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_number (m_block_number),
        .m_status       (m_status),
        .mem_en         (mem_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

endmodule

@@ tb/bitmap_block_allocator_test.sv @@
// self-checking testbench for bitmap_block_allocator: directed and random allocate/free
// transfers, checked against an in-bench bitmap predictor; needs bba_pkg and the rtl
`timescale 1ns / 100ps

module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic               op;
        logic [INDEX_W-1:0] index;
    } block_req_t;

    typedef struct {
        logic [INDEX_W-1:0] number;
        status_t            status;
    } block_grant_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_opcode = OP_ALLOC;
    logic [INDEX_W-1:0]  s_block_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [INDEX_W-1:0]  m_block_number;
    logic [STATUS_W-1:0] m_status;

    block_req_t          pending_reqs[$];
    block_grant_t        expected_grants[$];
    logic [BLOCK_SPAN-1:0] used_map = '0;
    int                  managed_blocks = BLOCK_SPAN;
    int                  idle_pct = 0;
    int                  errors = 0;
    int                  holds_asked = 0;
    int                  holds_done = 0;
    int                  hold_left = 0;
    int                  stall_left = 0;
    int                  send_gap = 0;

    bitmap_block_allocator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_block_index  (s_block_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_number (m_block_number),
        .m_status       (m_status)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int idle_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // first-fit allocate or free on the shadow bitmap
    task automatic apply_block_request(input logic op, input logic [INDEX_W-1:0] idx);
        block_grant_t grant;
        grant.number = '0;
        grant.status = STATUS_FULL;
        if (op == OP_ALLOC) begin
            for (int i = 0; i < managed_blocks; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    grant.number = i[INDEX_W-1:0];
                    grant.status = STATUS_DONE;
                    break;
                end
            end
        end else if (idx < managed_blocks) begin
            used_map[idx] = 1'b0;
            grant.number = idx;
            grant.status = STATUS_DONE;
        end else begin
            grant.status = STATUS_RANGE;
        end
        expected_grants.push_back(grant);
    endtask

    // driver
    always @(posedge aclk) begin
        block_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                apply_block_request(s_opcode, s_block_index);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= req.op;
                    s_block_index <= req.index;
                    send_gap <= idle_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side back-pressure
    always @(posedge aclk) begin
        block_grant_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected transfer, number %0d status %0d",
                             $time, m_block_number, m_status);
                    errors++;
                end else begin
                    want = expected_grants.pop_front();
                    if (m_block_number !== want.number) begin
                        $display("%0t: block_number expected %0d actual %0d",
                                 $time, want.number, m_block_number);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                end
            end
            if (holds_done < holds_asked) begin
                holds_done <= holds_done + 1;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left <= idle_gap();
            end
        end
    end

    task automatic queue_request(input logic op, input int idx);
        block_req_t req;
        req.op = op;
        req.index = idx[INDEX_W-1:0];
        pending_reqs.push_back(req);
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || s_valid || expected_grants.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic change_count(input int value);
        settle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[COUNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        managed_blocks = (value > BLOCK_SPAN) ? BLOCK_SPAN : value;
        if (managed_blocks > DEFAULT_BLOCKS) managed_blocks = DEFAULT_BLOCKS;
        @(negedge aclk);
    endtask

    task automatic queue_random(input int n, input int alloc_pct);
        int r;
        int lim;
        for (int k = 0; k < n; k++) begin
            lim = managed_blocks;
            if ($urandom_range(99) < alloc_pct) begin
                queue_request(OP_ALLOC, $urandom_range(1023));
            end else begin
                r = $urandom_range(99);
                if (lim == 0 || r >= 85)
                    queue_request(OP_FREE, $urandom_range(1023));
                else if (r < 45)
                    queue_request(OP_FREE, $urandom_range((lim > 64 ? 64 : lim) - 1));
                else
                    queue_request(OP_FREE, $urandom_range(lim - 1));
            end
        end
    endtask

    initial begin
        int phase_count[9] = '{1024, 33, 32, 1025, 2047, 0, 1, 0, 1024};
        int phase_items[9] = '{100, 80, 60, 80, 60, 10, 30, 80, 100};
        int phase_alloc[9] = '{60, 60, 55, 85, 50, 50, 50, 60, 90};
        int phase_idle[9]  = '{0, 30, 20, 10, 50, 20, 0, 30, 20};
        int count;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: small count, fill, double free, out of range
        change_count(4);
        repeat (5) queue_request(OP_ALLOC, 0);
        queue_request(OP_FREE, 2);
        queue_request(OP_FREE, 2);
        queue_request(OP_ALLOC, 1023);
        queue_request(OP_FREE, 4);
        queue_request(OP_FREE, 1023);
        queue_request(OP_FREE, 3);
        queue_request(OP_FREE, 0);

        // zero count
        change_count(0);
        queue_request(OP_ALLOC, 0);
        queue_request(OP_FREE, 0);

        // count above the block span
        change_count(2047);
        queue_request(OP_FREE, 1023);
        queue_request(OP_ALLOC, 0);
        queue_request(OP_ALLOC, 682);
        queue_request(OP_FREE, 512);
        queue_request(OP_FREE, 341);
        queue_request(OP_FREE, 682);

        // single block
        change_count(1);
        queue_request(OP_ALLOC, 0);
        queue_request(OP_FREE, 0);
        queue_request(OP_ALLOC, 0);

        for (int p = 0; p < 9; p++) begin
            count = (p == 7) ? $urandom_range(1024, 1) : phase_count[p];
            change_count(count);
            idle_pct = phase_idle[p];
            if (p == 8) begin
                // receiver holds off while the sender keeps offering
                idle_pct = 0;
                holds_asked = holds_asked + 1;
                queue_random(30, 70);
                settle();
                idle_pct = phase_idle[p];
                queue_random(phase_items[p], phase_alloc[p]);
                settle();
            end
            queue_random(phase_items[p], phase_alloc[p]);
        end

        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
